// File: design/grid_graph_reachability_assert.svh
// assertion macros used by the checker file
`ifndef GRID_GRAPH_REACHABILITY_ASSERT_SVH
`define GRID_GRAPH_REACHABILITY_ASSERT_SVH

// same-cycle implication, off during reset
`define GGR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ggr_pkg.sv
`default_nettype none

package ggr_pkg;

  localparam int GGR_GRID_W = 8;
  localparam int GGR_GRID_H = 8;
  localparam int COORD_W    = 3;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: design/grid_graph_reachability.sv
// channel | signals                          | word
// in      | in_valid / in_ready              | req_type, a_x, a_y, b_x, b_y, edge_on
// out     | out_valid / out_ready            | found
//
// an edge write reads the source row, then writes it back modified
// a query pops a cell, reads it from the stack ram, checks it against the target,
// reads its row from the edge ram and pushes the fresh cells; the registered ram
// reads on each pop and the one stack push per cycle set its length
// reset clears the edge map at once through one valid bit per row
// a finished answer waits in the output register; edge writes go on meanwhile,
// a following query runs but holds its answer until the output is taken
`default_nettype none

module grid_graph_reachability import ggr_pkg::*; #(
  parameter int GRID_W = GGR_GRID_W,
  parameter int GRID_H = GGR_GRID_H
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [COORD_W-1:0] a_x,
  input  logic [COORD_W-1:0] a_y,
  input  logic [COORD_W-1:0] b_x,
  input  logic [COORD_W-1:0] b_y,
  input  logic               edge_on,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found
);

  localparam int CELLS  = GRID_W * GRID_H;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SP_W   = CELL_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EWR   = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_ROW   = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0]        state;
  logic [SP_W-1:0]   sp;
  logic [CELLS-1:0]  marks;
  logic [CELLS-1:0]  fresh;
  logic [CELLS-1:0]  row_valid;
  logic [CELL_W-1:0] start_cell;
  logic [CELL_W-1:0] target_cell;
  logic [CELL_W-1:0] cur;
  logic              ew_on;
  logic              res_found;

  logic              accept;
  logic              a_ok;
  logic              b_ok;
  logic [CELL_W-1:0] a_cell;
  logic [CELL_W-1:0] b_cell;
  logic [SP_W-1:0]   sp_m1;
  logic [CELLS-1:0]  low_iso;
  logic [CELL_W-1:0] low_enc;
  logic [CELLS-1:0]  erow;
  logic [CELLS-1:0]  row_base;
  logic [CELLS-1:0]  ew_base;
  logic [CELLS-1:0]  ew_bit;
  logic [CELL_W-1:0] stk_rdata;
  logic              stk_wr_en;
  logic [CELL_W-1:0] stk_wr_addr;
  logic [CELL_W-1:0] stk_wr_data;
  logic              stk_rd_en;
  logic              edg_wr_en;
  logic [CELLS-1:0]  edg_wr_data;
  logic              edg_rd_en;
  logic [CELL_W-1:0] edg_rd_addr;
  logic              out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign a_ok   = (int'(a_x) < GRID_W) && (int'(a_y) < GRID_H);
  assign b_ok   = (int'(b_x) < GRID_W) && (int'(b_y) < GRID_H);
  assign a_cell = CELL_W'(int'(a_x) * GRID_H + int'(a_y));
  assign b_cell = CELL_W'(int'(b_x) * GRID_H + int'(b_y));

  assign sp_m1 = sp - 1'b1;

  // lowest fresh cell goes on the stack next
  assign low_iso = fresh & (~fresh + CELLS'(1));
  always_comb begin
    low_enc = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (low_iso[i]) begin
        low_enc = low_enc | CELL_W'(i);
      end
    end
  end

  // rows never written read as empty
  assign row_base = row_valid[cur] ? erow : '0;
  assign ew_base  = row_valid[start_cell] ? erow : '0;
  assign ew_bit   = CELLS'(1) << target_cell;

  // stack: start cell at query accept, then one fresh cell per push cycle
  assign stk_wr_en   = (accept && req_type == REQ_QUERY && a_ok && b_ok) ||
                       (state == S_PUSH && fresh != '0);
  assign stk_wr_addr = (state == S_IDLE) ? '0 : sp[CELL_W-1:0];
  assign stk_wr_data = (state == S_IDLE) ? a_cell : low_enc;
  assign stk_rd_en   = (state == S_POP) && (sp != '0);

  // edge map: row read for a write-back or for the popped cell
  assign edg_rd_en   = (accept && req_type == REQ_EDGE && a_ok && b_ok) ||
                       (state == S_CHECK);
  assign edg_rd_addr = (state == S_IDLE) ? a_cell : stk_rdata;
  assign edg_wr_en   = (state == S_EWR);
  assign edg_wr_data = ew_on ? (ew_base | ew_bit) : (ew_base & ~ew_bit);

  assign out_load = (state == S_RES) && (!out_valid || out_ready);

  ggr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (sp_m1[CELL_W-1:0]),
    .rd_data (stk_rdata)
  );

  ggr_ram #(
    .WIDTH (CELLS),
    .DEPTH (CELLS)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edg_wr_en),
    .wr_addr (start_cell),
    .wr_data (edg_wr_data),
    .rd_en   (edg_rd_en),
    .rd_addr (edg_rd_addr),
    .rd_data (erow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        found     <= res_found;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            start_cell  <= a_cell;
            target_cell <= b_cell;
            ew_on       <= edge_on;
            if (req_type == REQ_EDGE) begin
              if (a_ok && b_ok) begin
                state <= S_EWR;
              end
            end else if (a_ok && b_ok) begin
              marks <= CELLS'(1) << a_cell;
              sp    <= SP_W'(1);
              state <= S_POP;
            end else begin
              res_found <= 1'b0;
              state     <= S_RES;
            end
          end
        end
        S_EWR: begin
          row_valid[start_cell] <= 1'b1;
          state                 <= S_IDLE;
        end
        S_POP: begin
          if (sp == '0) begin
            res_found <= 1'b0;
            state     <= S_RES;
          end else begin
            sp    <= sp_m1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cur <= stk_rdata;
          // the start cell itself never counts as reaching the target
          if (stk_rdata != start_cell && stk_rdata == target_cell) begin
            res_found <= 1'b1;
            state     <= S_RES;
          end else begin
            state <= S_ROW;
          end
        end
        S_ROW: begin
          fresh <= row_base & ~marks;
          marks <= marks | row_base;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (fresh == '0) begin
            state <= S_POP;
          end else begin
            sp    <= sp + 1'b1;
            fresh <= fresh & (fresh - CELLS'(1));
          end
        end
        S_RES: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ggr_ram.sv
`default_nettype none

module ggr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/ggr_checker.sv
`default_nettype none
`include "grid_graph_reachability_assert.svh"

module ggr_checker import ggr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               req_type,
  input logic [COORD_W-1:0] a_x,
  input logic [COORD_W-1:0] a_y,
  input logic [COORD_W-1:0] b_x,
  input logic [COORD_W-1:0] b_y,
  input logic               edge_on,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found
);

  logic [1:0] pend;
  logic       q_in;
  logic       r_out;

  assign q_in  = in_valid && in_ready && (req_type == REQ_QUERY);
  assign r_out = out_valid && out_ready;

  // queries taken whose answer has not yet been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (q_in && !r_out) begin
      pend <= pend + 1'b1;
    end else if (r_out && !q_in) begin
      pend <= pend - 1'b1;
    end
  end

  `GGR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "answer dropped while stalled")
  `GGR_ASSERT_NEXT(a_found_hold, clk, rst, out_valid && !out_ready, $stable(found), "answer changed while stalled")
  `GGR_ASSERT_NOW(a_no_spurious, clk, rst, out_valid, pend != 2'd0, "answer with no query outstanding")
  `GGR_ASSERT_NOW(a_two_max, clk, rst, pend == 2'd2, !in_ready, "word taken with two answers owed")

endmodule

bind grid_graph_reachability ggr_checker u_ggr_checker (.*);

`default_nettype wire

// File: verif/tb_grid_graph_reachability.sv
`timescale 1ns / 1ps

module tb_grid_graph_reachability;
  import ggr_pkg::*;

  localparam int CELLS       = GGR_GRID_W * GGR_GRID_H;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 400;
  localparam int RAND_WORDS  = 1200;

  // edge map mirror and queue of pending query answers
  class reach_scoreboard;
    logic [CELLS-1:0] edge_rows [CELLS];
    bit               found_q [$];
    int               errors;

    function new();
      foreach (edge_rows[i]) edge_rows[i] = '0;
      errors = 0;
    endfunction

    function bit cell_ok(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      return (x < GGR_GRID_W) && (y < GGR_GRID_H);
    endfunction

    function int cell_num(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      return (x * GGR_GRID_H + y) % CELLS;
    endfunction

    // depth-first walk; the start is marked up front and never counts as the target
    function bit reachable(int start, int target);
      logic [CELLS-1:0] marks;
      logic [CELLS-1:0] fresh;
      int               stk [CELLS];
      int               depth;
      int               cur;
      marks        = '0;
      stk[0]       = start;
      depth        = 1;
      marks[start] = 1'b1;
      while (depth > 0) begin
        depth--;
        cur = stk[depth];
        if (cur != start && cur == target) return 1'b1;
        fresh = edge_rows[cur] & ~marks;
        for (int d = 0; d < CELLS; d++) begin
          if (fresh[d]) begin
            if (depth < CELLS) begin
              stk[depth] = d;
              depth++;
            end
            marks[d] = 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_word(logic rt, logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                            logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by, logic eo);
      bit ok;
      ok = cell_ok(ax, ay) && cell_ok(bx, by);
      if (rt == REQ_EDGE) begin
        if (ok) edge_rows[cell_num(ax, ay)][cell_num(bx, by)] = eo;
      end else begin
        found_q.push_back(ok ? reachable(cell_num(ax, ay), cell_num(bx, by)) : 1'b0);
      end
    endfunction

    function void check_found(logic got);
      bit want;
      if (found_q.size() == 0) begin
        $display("%0t: found expected none, got %0b", $time, got);
        errors++;
      end else begin
        want = found_q.pop_front();
        if (got !== want) begin
          $display("%0t: found expected %0b, got %0b", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return found_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic [COORD_W-1:0] a_x;
  logic [COORD_W-1:0] a_y;
  logic [COORD_W-1:0] b_x;
  logic [COORD_W-1:0] b_y;
  logic               edge_on;
  logic               out_valid;
  logic               out_ready;
  logic               found;

  reach_scoreboard sb = new();
  int              cycles = 0;

  grid_graph_reachability u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .edge_on  (edge_on),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found    (found)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_grid_graph_reachability failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(req_type, a_x, a_y, b_x, b_y, edge_on);
      if (out_valid && out_ready) sb.check_found(found);
    end
  end

  // receiver stall pattern: runs of always-ready, coin-flip and mostly-stalled
  initial begin
    int mode;
    int len;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic rt, int ax, int ay, int bx, int by, logic eo);
    in_valid <= 1'b1;
    req_type <= rt;
    a_x      <= COORD_W'(ax);
    a_y      <= COORD_W'(ay);
    b_x      <= COORD_W'(bx);
    b_y      <= COORD_W'(by);
    edge_on  <= eo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // mostly maze-like moves to a neighbour, now and then a long jump
  task automatic send_random_edge(int on_pct);
    int sx, sy, dx, dy;
    sx = $urandom_range(0, GGR_GRID_W - 1);
    sy = $urandom_range(0, GGR_GRID_H - 1);
    dx = sx;
    dy = sy;
    if ($urandom_range(0, 4) == 0) begin
      dx = $urandom_range(0, GGR_GRID_W - 1);
      dy = $urandom_range(0, GGR_GRID_H - 1);
    end else begin
      case ($urandom_range(0, 3))
        0:       if (sx < GGR_GRID_W - 1) dx = sx + 1;
        1:       if (sx > 0) dx = sx - 1;
        2:       if (sy < GGR_GRID_H - 1) dy = sy + 1;
        default: if (sy > 0) dy = sy - 1;
      endcase
    end
    send_word(REQ_EDGE, sx, sy, dx, dy, $urandom_range(1, 100) <= on_pct);
  endtask

  task automatic send_random_query();
    int sx, sy;
    sx = $urandom_range(0, GGR_GRID_W - 1);
    sy = $urandom_range(0, GGR_GRID_H - 1);
    if ($urandom_range(0, 9) == 0)
      send_word(REQ_QUERY, sx, sy, sx, sy, 1'($urandom_range(0, 1)));
    else
      send_word(REQ_QUERY, sx, sy, $urandom_range(0, GGR_GRID_W - 1),
                $urandom_range(0, GGR_GRID_H - 1), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int sent;
    int burst;
    int on_pct;
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_EDGE;
    a_x      = '0;
    a_y      = '0;
    b_x      = '0;
    b_y      = '0;
    edge_on  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: corners, cycles back to the start, self edges, clearing
    send_word(REQ_QUERY, 0, 0, 7, 7, 1'b0);
    send_word(REQ_EDGE,  0, 0, 7, 7, 1'b1);
    send_word(REQ_QUERY, 0, 0, 7, 7, 1'b1);
    send_word(REQ_QUERY, 7, 7, 0, 0, 1'b0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 1'b0);
    send_word(REQ_EDGE,  7, 7, 0, 0, 1'b1);
    send_word(REQ_QUERY, 0, 0, 0, 0, 1'b1);
    send_word(REQ_QUERY, 7, 7, 7, 7, 1'b0);
    idle_gap(3);
    send_word(REQ_EDGE,  3, 4, 3, 4, 1'b1);
    send_word(REQ_QUERY, 3, 4, 3, 4, 1'b0);
    send_word(REQ_EDGE,  7, 7, 3, 4, 1'b1);
    send_word(REQ_QUERY, 0, 0, 3, 4, 1'b0);
    send_word(REQ_EDGE,  0, 0, 7, 7, 1'b0);
    send_word(REQ_QUERY, 0, 0, 3, 4, 1'b1);
    send_word(REQ_QUERY, 7, 7, 3, 4, 1'b0);
    send_word(REQ_EDGE,  7, 0, 0, 7, 1'b1);
    send_word(REQ_QUERY, 7, 0, 0, 7, 1'b0);
    send_word(REQ_EDGE,  2, 5, 5, 2, 1'b0);
    send_word(REQ_QUERY, 2, 5, 5, 2, 1'b1);
    send_word(REQ_EDGE,  5, 2, 2, 5, 1'b1);
    send_word(REQ_QUERY, 5, 2, 0, 0, 1'b0);
    send_word(REQ_EDGE,  0, 7, 5, 2, 1'b1);
    send_word(REQ_QUERY, 7, 0, 2, 5, 1'b0);

    sent   = 0;
    on_pct = 60;
    while (sent < RAND_WORDS) begin
      // edge density drifts so that answers swing between sparse and dense maps
      if (sent % 150 == 0) on_pct = $urandom_range(30, 85);
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 55) send_random_edge(on_pct);
        else send_random_query();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_grid_graph_reachability passed");
    else
      $display("tb_grid_graph_reachability failed");
    $finish;
  end

endmodule
